### rtl/hct_pkg.sv
// Shared types, constants and helpers of the hashed count table.
// Used by hct_ctrl, hct_datapath and hashed_count_table_top; no dependencies.
package hct_pkg;

  // Table geometry. The bucket count must be a power of two, because the bucket
  // is taken from the low bits of the key.
  localparam int NUM_BUCKETS      = 8;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  localparam int KEY_W   = 32;
  localparam int DELTA_W = 32;
  localparam int COUNT_W = 31;
  localparam int SUM_W   = COUNT_W + 3;

  localparam logic signed [SUM_W-1:0] COUNT_MAX_S = SUM_W'({COUNT_W{1'b1}});

  typedef enum logic [1:0] {
    FN_QUERY  = 2'd0,
    FN_INSERT = 2'd1,
    FN_ADD    = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_PRESENT    = 3'd2,
    ST_FULL       = 3'd3,
    ST_CLAMP_ZERO = 3'd4,
    ST_SAT_HIGH   = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;       // capture the input beat
    logic              rd_en;      // read one slot of the bucket
    logic              rd_sel_in;  // address from the input key instead of the held key
    logic [SLOT_W-1:0] rd_slot;    // slot within the bucket
    logic              cmp_en;     // evaluate the slot read in the previous cycle
    logic              exec;       // apply the operation and load the result register
  } hct_cmd_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    return BKT_W'(key % NUM_BUCKETS);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0]  bkt,
                                                  input logic [SLOT_W-1:0] slot);
    return ADDR_W'(int'(bkt) * SLOTS_PER_BUCKET + int'(slot));
  endfunction

endpackage

### rtl/hct_ctrl.sv
// Sequencer of the hashed count table: accept, bucket scan, execute, result.
// Depends on hct_pkg.
module hct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hct_pkg::hct_cmd_t cmd_o
);
  import hct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_EXEC
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // Slot zero is read in the accept cycle, straight from the input key.
          cmd_o.load      = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel_in = 1'b1;
          slot_d          = SLOT_W'(1);
          state_d         = (SLOTS_PER_BUCKET > 1) ? S_SCAN : S_LAST;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_slot = slot_q;
        cmd_o.cmp_en  = 1'b1;
        slot_d        = slot_q + SLOT_W'(1);
        if (slot_q == SLOT_W'(SLOTS_PER_BUCKET - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        cmd_o.cmp_en = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/hct_datapath.sv
// Datapath of the hashed count table: slot memory, valid bits, scan and result.
// Depends on hct_pkg.
module hct_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hct_pkg::hct_cmd_t               cmd_i,
  input  logic [1:0]                      func_i,
  input  logic [hct_pkg::KEY_W-1:0]       item_key_i,
  input  logic signed [hct_pkg::DELTA_W-1:0] delta_i,
  output logic [2:0]                      status_o,
  output logic [hct_pkg::COUNT_W-1:0]     count_now_o,
  output logic [hct_pkg::COUNT_W-1:0]     count_before_o
);
  import hct_pkg::*;

  // Held operation.
  func_e                     func_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [DELTA_W-1:0] delta_q;

  // Slot storage.
  logic [KEY_W-1:0]   key_mem [TOTAL_SLOTS];
  logic [COUNT_W-1:0] cnt_mem [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] valid_q;

  // Registered read port.
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [KEY_W-1:0]   rd_key_q;
  logic [COUNT_W-1:0] rd_cnt_q;
  logic               rd_valid_q;

  // Scan results.
  logic               hit_q, free_q;
  logic [ADDR_W-1:0]  hit_addr_q, free_addr_q;
  logic [COUNT_W-1:0] before_q;

  // Execute stage.
  logic signed [SUM_W-1:0] before_ext, delta_ext, sum;
  status_e            status_d;
  logic [COUNT_W-1:0] now_d, prev_d;
  logic               wr_en, set_valid, clr_valid;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_cnt;

  status_e            status_q;
  logic [COUNT_W-1:0] now_q, prev_q;

  assign rd_addr = cmd_i.rd_sel_in ? slot_addr(bucket_of(item_key_i), '0)
                                   : slot_addr(bucket_of(key_q), cmd_i.rd_slot);

  assign before_ext = {3'b000, before_q};
  assign delta_ext  = {{(SUM_W - DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
  assign sum        = before_ext + delta_ext;

  always_comb begin
    status_d  = ST_OK;
    now_d     = '0;
    prev_d    = hit_q ? before_q : '0;
    wr_en     = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    wr_addr   = hit_addr_q;
    wr_cnt    = '0;
    case (func_q)
      FN_QUERY: begin
        if (hit_q) begin
          now_d = before_q;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      FN_INSERT: begin
        if (hit_q) begin
          status_d = ST_PRESENT;
          now_d    = before_q;
        end else if (free_q) begin
          wr_en     = 1'b1;
          set_valid = 1'b1;
          wr_addr   = free_addr_q;
        end else begin
          status_d = ST_FULL;
        end
      end
      FN_ADD: begin
        if (hit_q) begin
          if (sum < 0) begin
            status_d = ST_CLAMP_ZERO;
          end else if (sum > COUNT_MAX_S) begin
            status_d = ST_SAT_HIGH;
            now_d    = COUNT_MAX_S[COUNT_W-1:0];
          end else begin
            now_d = sum[COUNT_W-1:0];
          end
          wr_en  = 1'b1;
          wr_cnt = now_d;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      FN_REMOVE: begin
        if (hit_q) begin
          clr_valid = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  // Memory and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_e'(func_i);
      key_q   <= item_key_i;
      delta_q <= delta_i;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_cnt_q <= cnt_mem[rd_addr];
    end
    if (cmd_i.exec && wr_en) begin
      key_mem[wr_addr] <= key_q;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      now_q    <= now_d;
      prev_q   <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      rd_addr_q   <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_addr_q  <= '0;
      free_addr_q <= '0;
      before_q    <= '0;
    end else begin
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
        rd_addr_q  <= rd_addr;
      end
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.cmp_en) begin
        if (rd_valid_q && (rd_key_q == key_q) && !hit_q) begin
          hit_q      <= 1'b1;
          hit_addr_q <= rd_addr_q;
          before_q   <= rd_cnt_q;
        end
        if (!rd_valid_q && !free_q) begin
          free_q      <= 1'b1;
          free_addr_q <= rd_addr_q;
        end
      end
      if (cmd_i.exec && set_valid) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.exec && clr_valid) begin
        valid_q[hit_addr_q] <= 1'b0;
      end
    end
  end

  assign status_o       = status_q;
  assign count_now_o    = now_q;
  assign count_before_o = prev_q;

endmodule

### rtl/hashed_count_table_top.sv
// The bucket is scanned through the single read port of the slot memory, which reads one slot
// of the bucket per cycle; a new input beat is taken only after the previous one has executed.
// The result sits in an output register, so the next input beat is taken while it waits.
// Reset (rst_ni low, asynchronous) clears all slot valid bits and the control state at once;
// slot keys and counts are not cleared and are only read behind a set valid bit.
// Top level of the hashed count table; depends on hct_pkg, hct_ctrl and hct_datapath.
module hashed_count_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      func_i,
  input  logic [hct_pkg::KEY_W-1:0]       item_key_i,
  input  logic signed [hct_pkg::DELTA_W-1:0] delta_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [hct_pkg::COUNT_W-1:0]     count_now_o,
  output logic [hct_pkg::COUNT_W-1:0]     count_before_o
);
  import hct_pkg::*;

  // The controller walks the bucket one slot per cycle; the datapath compares
  // each registered read against the held key in the next cycle, remembers the
  // matching slot and the lowest free slot, and applies the operation in the
  // execute cycle. The execute cycle waits while the output register is full.
  hct_cmd_t cmd;

  hct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  hct_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .item_key_i     (item_key_i),
    .delta_i        (delta_i),
    .status_o       (status_o),
    .count_now_o    (count_now_o),
    .count_before_o (count_before_o)
  );

  // An accepted beat keeps the input closed until its bucket has been scanned.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after a beat");

  // A result is only produced into a free or draining output register.
  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote a pending output beat");

  // The output only turns valid through an execute cycle.
  a_valid_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.exec))
    else $error("output valid without an executed operation");

  // A count clamped at zero is reported as zero.
  a_clamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_CLAMP_ZERO)) |-> (count_now_o == '0))
    else $error("clamped result with nonzero count");

endmodule
